// ----- hw/rtl/rrwt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrwt_pkg
// shared widths, defaults and the command type between front end and back end
// ----------------------------------------------------------------------------
package rrwt_pkg;

  localparam int BURST_W           = 16;
  localparam int JOB_W             = 6;
  localparam int TIME_W            = 22;
  localparam int MAX_PROCESSES_DEF = 16;

  localparam logic [BURST_W-1:0] QUANTUM_RESET = 16'd4;

  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic               last;
    logic               store;
  } cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rrwt_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrwt_queue
// two-entry command queue between the intake front end and the scheduler
// ----------------------------------------------------------------------------
module rrwt_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire rrwt_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                pop_valid,
  output rrwt_pkg::cmd_t      pop_data
);

  rrwt_pkg::cmd_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rrwt_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrwt_front
// intake: takes one beat per cycle while not busy, marks beats beyond capacity as
// dropped, closes the batch on the last beat until the scheduler reports done
// ----------------------------------------------------------------------------
module rrwt_front #(
  parameter int MAX_PROCESSES = rrwt_pkg::MAX_PROCESSES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [rrwt_pkg::BURST_W-1:0] burst_time,
  input  wire logic                         is_last,
  output logic                              busy,
  input  wire logic                         done,
  input  wire logic                         q_full,
  output logic                              push,
  output rrwt_pkg::cmd_t                    push_data
);

  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

  logic [CNT_W-1:0] cnt;
  logic             closed;
  logic             store;

  assign busy  = closed | q_full;
  assign push  = start & ~busy;
  assign store = (cnt < CNT_W'(MAX_PROCESSES));

  always_comb begin
    push_data.burst = burst_time;
    push_data.last  = is_last;
    push_data.store = store;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      closed <= 1'b0;
    end else begin
      if (push && is_last) begin
        cnt    <= '0;
        closed <= 1'b1;
      end else begin
        if (push && store) begin
          cnt <= cnt + CNT_W'(1);
        end
        if (done) begin
          closed <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rrwt_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrwt_back
// scheduler: stores jobs, walks the round-robin order over the job memories,
// then sweeps the jobs in load order and emits one result per job
// ----------------------------------------------------------------------------
module rrwt_back #(
  parameter int MAX_PROCESSES = rrwt_pkg::MAX_PROCESSES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         quantum_we,
  input  wire logic [rrwt_pkg::BURST_W-1:0] quantum_wdata,
  input  wire logic                         q_valid,
  input  wire rrwt_pkg::cmd_t               q_data,
  output logic                              pop,
  output logic                              done,
  output logic                              valid,
  output logic [rrwt_pkg::JOB_W-1:0]        job_index,
  output logic [rrwt_pkg::TIME_W-1:0]       waiting_time,
  output logic [rrwt_pkg::TIME_W-1:0]       completion_time,
  output logic                              last_result
);

  localparam int IDX_W = $clog2(MAX_PROCESSES);
  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam int BW    = rrwt_pkg::BURST_W;
  localparam int TW    = rrwt_pkg::TIME_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRD,
    S_WEX,
    S_ORD,
    S_OEM
  } state_t;

  state_t           state;
  logic [BW-1:0]    quantum;
  logic [IDX_W-1:0] k;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] pending;
  logic [TW-1:0]    tick;

  logic [BW-1:0] rem_mem [MAX_PROCESSES];
  logic [BW-1:0] bst_mem [MAX_PROCESSES];
  logic [TW-1:0] fin_mem [MAX_PROCESSES];
  logic [BW-1:0] rem_q;
  logic [BW-1:0] bst_q;
  logic [TW-1:0] fin_q;

  logic             load;
  logic             rem_we;
  logic             fin_we;
  logic [IDX_W-1:0] wr_idx;
  logic [BW-1:0]    rem_wdata;
  logic [TW-1:0]    fin_wdata;

  logic [BW-1:0]    q_eff;
  logic [BW-1:0]    slice;
  logic [BW-1:0]    rem_new;
  logic [TW-1:0]    tick_n;
  logic             k_wrap;
  logic [CNT_W-1:0] pend_load;
  logic [CNT_W-1:0] pend_walk;

  assign q_eff     = (quantum == '0) ? BW'(1) : quantum;
  assign slice     = (rem_q < q_eff) ? rem_q : q_eff;
  assign rem_new   = rem_q - slice;
  assign tick_n    = tick + TW'(slice);
  assign k_wrap    = ((CNT_W'(k) + CNT_W'(1)) == n);
  assign pop       = (state == S_IDLE) & q_valid;
  assign load      = pop & q_data.store;
  assign pend_load = pending + ((q_data.burst != '0) ? CNT_W'(1) : CNT_W'(0));
  assign pend_walk = pending - CNT_W'(1);
  assign done      = (state == S_OEM) & k_wrap;

  always_comb begin
    rem_we    = 1'b0;
    fin_we    = 1'b0;
    wr_idx    = k;
    rem_wdata = rem_new;
    fin_wdata = tick_n;
    if (load) begin
      rem_we    = 1'b1;
      fin_we    = 1'b1;
      wr_idx    = n[IDX_W-1:0];
      rem_wdata = q_data.burst;
      fin_wdata = '0;
    end else if (state == S_WEX && rem_q != '0) begin
      rem_we = 1'b1;
      fin_we = (rem_new == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[wr_idx] <= rem_wdata;
    end
    if (load) begin
      bst_mem[wr_idx] <= q_data.burst;
    end
    if (fin_we) begin
      fin_mem[wr_idx] <= fin_wdata;
    end
    rem_q <= rem_mem[k];
    bst_q <= bst_mem[k];
    fin_q <= fin_mem[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= rrwt_pkg::QUANTUM_RESET;
      state   <= S_IDLE;
      k       <= '0;
      n       <= '0;
      pending <= '0;
      tick    <= '0;
      valid   <= 1'b0;
    end else begin
      if (quantum_we) begin
        quantum <= quantum_wdata;
      end
      valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (q_data.store) begin
              n       <= n + CNT_W'(1);
              pending <= pend_load;
            end
            if (q_data.last) begin
              k    <= '0;
              tick <= '0;
              if ((q_data.store ? pend_load : pending) == '0) begin
                state <= S_ORD;
              end else begin
                state <= S_WRD;
              end
            end
          end
        end
        S_WRD: begin
          state <= S_WEX;
        end
        S_WEX: begin
          k <= k_wrap ? '0 : k + IDX_W'(1);
          if (rem_q != '0) begin
            tick <= tick_n;
            if (rem_new == '0) begin
              pending <= pend_walk;
              if (pend_walk == '0) begin
                k     <= '0;
                state <= S_ORD;
              end else begin
                state <= S_WRD;
              end
            end else begin
              state <= S_WRD;
            end
          end else begin
            state <= S_WRD;
          end
        end
        S_ORD: begin
          state <= S_OEM;
        end
        S_OEM: begin
          valid           <= 1'b1;
          job_index       <= (rrwt_pkg::JOB_W)'(k);
          completion_time <= fin_q;
          waiting_time    <= fin_q - TW'(bst_q);
          last_result     <= k_wrap;
          if (k_wrap) begin
            state   <= S_IDLE;
            k       <= '0;
            n       <= '0;
            pending <= '0;
            tick    <= '0;
          end else begin
            k     <= k + IDX_W'(1);
            state <= S_ORD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/round_robin_wait_time_calc_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_wait_time_calc_unit
// round-robin scheduling of a batch of jobs that all arrive at tick zero
// ----------------------------------------------------------------------------
// Bursts are taken one beat per cycle while busy is low, through a two-entry
// queue while a batch loads. The beat marked is_last closes the batch and busy
// stays high until the last result is out. The walk then visits each job slot
// in turn, finished jobs included, with a memory read state (S_WRD) and an
// update state (S_WEX) per visit. Results follow in load order, each read in
// S_ORD and emitted in S_OEM, each on the result ports for one cycle with valid
// high; the receiver cannot stall them. No clearing pass is needed after reset.
module round_robin_wait_time_calc_unit #(
  parameter int MAX_PROCESSES = rrwt_pkg::MAX_PROCESSES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          time_quantum_we,
  input  wire logic [rrwt_pkg::BURST_W-1:0]  time_quantum,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [rrwt_pkg::BURST_W-1:0]  burst_time,
  input  wire logic                          is_last,
  output logic                               valid,
  output logic [rrwt_pkg::JOB_W-1:0]         job_index,
  output logic [rrwt_pkg::TIME_W-1:0]        waiting_time,
  output logic [rrwt_pkg::TIME_W-1:0]        completion_time,
  output logic                               last_result
);

  logic           push;
  rrwt_pkg::cmd_t push_data;
  logic           q_full;
  logic           pop;
  logic           q_valid;
  rrwt_pkg::cmd_t q_data;
  logic           done;

  rrwt_front #(
    .MAX_PROCESSES(MAX_PROCESSES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .burst_time (burst_time),
    .is_last    (is_last),
    .busy       (busy),
    .done       (done),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  rrwt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  rrwt_back #(
    .MAX_PROCESSES(MAX_PROCESSES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .quantum_we      (time_quantum_we),
    .quantum_wdata   (time_quantum),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .pop             (pop),
    .done            (done),
    .valid           (valid),
    .job_index       (job_index),
    .waiting_time    (waiting_time),
    .completion_time (completion_time),
    .last_result     (last_result)
  );

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    start && !busy && is_last |=> busy)
    else $error("batch not closed after last beat");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    valid && !last_result |=> !valid ##1
      (valid && job_index == $past(job_index, 2) + 6'd1))
    else $error("result beats out of order");

  a_wait_bound: assert property (@(posedge clk) disable iff (rst)
    valid |-> completion_time >= waiting_time)
    else $error("waiting time exceeds completion time");

endmodule
`default_nettype wire

// ----- tb/sv/rrwt_checker.sv -----
// ----------------------------------------------------------------------------
// rrwt_checker
// watches the job intake, the quantum register and the result port of the
// round-robin unit, replays each batch through its own round-robin schedule
// and compares every result beat field by field against the oldest prediction
// ----------------------------------------------------------------------------
module rrwt_checker #(
  parameter int MAX_PROCESSES = rrwt_pkg::MAX_PROCESSES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          time_quantum_we,
  input  logic [rrwt_pkg::BURST_W-1:0]  time_quantum,
  input  logic                          start,
  input  logic                          busy,
  input  logic [rrwt_pkg::BURST_W-1:0]  burst_time,
  input  logic                          is_last,
  input  logic                          valid,
  input  logic [rrwt_pkg::JOB_W-1:0]    job_index,
  input  logic [rrwt_pkg::TIME_W-1:0]   waiting_time,
  input  logic [rrwt_pkg::TIME_W-1:0]   completion_time,
  input  logic                          last_result,
  output int                            errors,
  output int                            results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [22:0] TICK_CAP = 23'd4194240;

  typedef struct packed {
    logic [rrwt_pkg::JOB_W-1:0]  idx;
    logic [rrwt_pkg::TIME_W-1:0] wt;
    logic [rrwt_pkg::TIME_W-1:0] ct;
    logic                        fin;
  } job_result_t;

  logic [rrwt_pkg::BURST_W-1:0] slice_len;
  logic [rrwt_pkg::BURST_W-1:0] left_burst [MAX_PROCESSES];
  logic [22:0]                  preempt_at [MAX_PROCESSES];
  logic [22:0]                  wait_acc   [MAX_PROCESSES];
  logic [22:0]                  done_at    [MAX_PROCESSES];
  int unsigned                  n_loaded;
  job_result_t                  result_q [$];

  function automatic logic [22:0] tick_add(logic [22:0] a, logic [22:0] b);
    logic [23:0] s;
    s = a + b;
    return (s > TICK_CAP) ? TICK_CAP : s[22:0];
  endfunction

  function void schedule_batch();
    int unsigned                  pending;
    int unsigned                  k;
    logic [22:0]                  now;
    logic [rrwt_pkg::BURST_W-1:0] q;
    logic [rrwt_pkg::BURST_W-1:0] part;
    job_result_t                  r;
    q = (slice_len == '0) ? rrwt_pkg::BURST_W'(1) : slice_len;
    pending = 0;
    k = 0;
    now = '0;
    for (int i = 0; i < n_loaded; i++) begin
      if (left_burst[i] != '0) pending++;
    end
    while (pending != 0) begin
      if (left_burst[k] != '0) begin
        part = (left_burst[k] < q) ? left_burst[k] : q;
        wait_acc[k] = tick_add(wait_acc[k], now - preempt_at[k]);
        now = tick_add(now, 23'(part));
        left_burst[k] = left_burst[k] - part;
        if (left_burst[k] == '0) begin
          done_at[k] = now;
          pending--;
        end else begin
          preempt_at[k] = now;
        end
      end
      k = (k + 1 >= n_loaded) ? 0 : k + 1;
    end
    for (int i = 0; i < n_loaded; i++) begin
      r.idx = rrwt_pkg::JOB_W'(i);
      r.wt  = wait_acc[i][rrwt_pkg::TIME_W-1:0];
      r.ct  = done_at[i][rrwt_pkg::TIME_W-1:0];
      r.fin = (i + 1 == n_loaded);
      result_q.push_back(r);
    end
    n_loaded = 0;
  endfunction

  function void load_job(logic [rrwt_pkg::BURST_W-1:0] b, logic l);
    if (n_loaded < MAX_PROCESSES) begin
      left_burst[n_loaded] = b;
      preempt_at[n_loaded] = '0;
      wait_acc[n_loaded]   = '0;
      done_at[n_loaded]    = '0;
      n_loaded++;
    end
    if (l) schedule_batch();
  endfunction

  function void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    job_result_t want;
    if (rst) begin
      slice_len = rrwt_pkg::QUANTUM_RESET;
      n_loaded = 0;
      errors = 0;
      result_q.delete();
    end else begin
      if (valid) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual job %0d", $time,
                   job_index);
          errors++;
        end else begin
          want = result_q.pop_front();
          check_field("job_index", want.idx, job_index);
          check_field("waiting_time", want.wt, waiting_time);
          check_field("completion_time", want.ct, completion_time);
          check_field("last_result", want.fin, last_result);
        end
      end
      if (time_quantum_we) slice_len = time_quantum;
      if (start && !busy) load_job(burst_time, is_last);
    end
    results_due <= result_q.size();
  end

endmodule

// ----- tb/sv/tb_round_robin_wait_time_calc_unit.sv -----
// ----------------------------------------------------------------------------
// tb_round_robin_wait_time_calc_unit
// drives job batches into the round-robin unit: a directed set of corner
// batches, then random phases with a fresh quantum each, random bursts and
// batch lengths (overlong batches included) and random idle bursts; the
// checker beside the unit predicts and compares every result beat
// ----------------------------------------------------------------------------
module tb_round_robin_wait_time_calc_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           time_quantum_we = 1'b0;
  logic [rrwt_pkg::BURST_W-1:0]   time_quantum = '0;
  logic                           start = 1'b0;
  logic [rrwt_pkg::BURST_W-1:0]   burst_time = '0;
  logic                           is_last = 1'b0;
  logic                           busy;
  logic                           valid;
  logic [rrwt_pkg::JOB_W-1:0]     job_index;
  logic [rrwt_pkg::TIME_W-1:0]    waiting_time;
  logic [rrwt_pkg::TIME_W-1:0]    completion_time;
  logic                           last_result;
  int                             errors;
  int                             results_due;

  int                             jobs_sent = 0;
  int                             batches_sent = 0;
  bit                             allow_gaps = 1'b1;
  logic [rrwt_pkg::BURST_W-1:0]   cur_quantum = rrwt_pkg::QUANTUM_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  round_robin_wait_time_calc_unit DUT (
    .clk             (clk),
    .rst             (rst),
    .time_quantum_we (time_quantum_we),
    .time_quantum    (time_quantum),
    .start           (start),
    .busy            (busy),
    .burst_time      (burst_time),
    .is_last         (is_last),
    .valid           (valid),
    .job_index       (job_index),
    .waiting_time    (waiting_time),
    .completion_time (completion_time),
    .last_result     (last_result)
  );

  rrwt_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .time_quantum_we (time_quantum_we),
    .time_quantum    (time_quantum),
    .start           (start),
    .busy            (busy),
    .burst_time      (burst_time),
    .is_last         (is_last),
    .valid           (valid),
    .job_index       (job_index),
    .waiting_time    (waiting_time),
    .completion_time (completion_time),
    .last_result     (last_result),
    .errors          (errors),
    .results_due     (results_due)
  );

  task automatic send_job(logic [rrwt_pkg::BURST_W-1:0] b, logic l);
    start <= 1'b1;
    burst_time <= b;
    is_last <= l;
    do @(posedge clk); while (busy);
    jobs_sent++;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_quantum(logic [rrwt_pkg::BURST_W-1:0] q);
    time_quantum_we <= 1'b1;
    time_quantum <= q;
    @(posedge clk);
    time_quantum_we <= 1'b0;
    cur_quantum = q;
  endtask

  // bursts stay within 16 slices so the schedule walk stays short
  function automatic logic [rrwt_pkg::BURST_W-1:0] rand_burst();
    int q;
    int cap;
    q = (cur_quantum == '0) ? 1 : int'(cur_quantum);
    cap = q * 16;
    if (cap > 65535) cap = 65535;
    case ($urandom_range(0, 15))
      0: return '0;
      1: return rrwt_pkg::BURST_W'(q);
      2: return rrwt_pkg::BURST_W'(cap);
      default: return rrwt_pkg::BURST_W'($urandom_range(1, cap));
    endcase
  endfunction

  function automatic logic [rrwt_pkg::BURST_W-1:0] pick_quantum();
    case ($urandom_range(0, 7))
      0: return 16'd1;
      1: return 16'hFFFF;
      2: return '0;
      3: return rrwt_pkg::BURST_W'($urandom_range(2, 8));
      4, 5: return rrwt_pkg::BURST_W'($urandom_range(1, 65535));
      default: return rrwt_pkg::BURST_W'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic send_batch();
    int len;
    len = (batches_sent % 5 == 4) ? $urandom_range(17, 20) : $urandom_range(1, 16);
    for (int i = 0; i < len; i++) send_job(rand_burst(), i == len - 1);
    batches_sent++;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset quantum: zero burst, short, exact and multi-slice jobs
    send_job(16'd0, 1'b0);
    send_job(16'd1, 1'b0);
    send_job(16'd4, 1'b0);
    send_job(16'd5, 1'b0);
    send_job(16'd10, 1'b1);
    send_job(16'd7, 1'b1);
    drain();
    set_quantum(16'hFFFF);
    send_job(16'hFFFF, 1'b0);
    send_job(16'h8000, 1'b0);
    send_job(16'd1, 1'b1);
    drain();
    // zero quantum acts as one tick
    set_quantum('0);
    send_job(16'd3, 1'b0);
    send_job(16'd0, 1'b0);
    send_job(16'd2, 1'b1);
    drain();
    set_quantum(16'd1);
    send_job(16'd0, 1'b0);
    send_job(16'd0, 1'b1);

    while (jobs_sent < 300) begin
      drain();
      set_quantum(pick_quantum());
      allow_gaps = (jobs_sent < 250) && ($urandom_range(0, 2) != 0);
      repeat ($urandom_range(2, 5)) send_batch();
    end
    drain();
    repeat (16) @(posedge clk);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
